>>> rtl/core/tssg_pkg.sv
// Shared constants for the triangle scanline span generator.
// No dependencies; imported by the span generator top level and its crossing unit.
`timescale 1ns / 1ps

package tssg_pkg;

    // Default signed width of every coordinate
    localparam int TSSG_COORD_BITS = 12;

    // Item operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

endpackage : tssg_pkg

>>> rtl/core/triangle_scanline_span_generator.sv
// Triangle scanline span generator top level: vertex sort, row walk and result register.
// Depends on tssg_pkg and on two tssg_cross units for the long and short edge crossings.
`timescale 1ns / 1ps

// A load item (op 0) gives no result and sorts the three vertices by y.
// A step item (op 1) gives exactly one result, shown for one cycle with o_strobe high; the
// receiver cannot stall, so results must be taken as they appear. When no rows remain the
// answer comes in the cycle after the step is accepted, with o_span_valid 0 and o_last 1. A
// span keeps busy high until the serial restoring dividers, one quotient bit per cycle,
// are done; the long and short edge crossings are computed side by side. The strobe cycle
// overlaps the first cycle in which the next item may be accepted.
module triangle_scanline_span_generator #(
    parameter int COORD_BITS = tssg_pkg::TSSG_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_op,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    input  logic [31:0]                  i_fill_color,
    output logic                         o_strobe,
    output logic                         o_span_valid,
    output logic signed [COORD_BITS-1:0] o_row,
    output logic signed [COORD_BITS-1:0] o_long_edge_x,
    output logic signed [COORD_BITS-1:0] o_short_edge_x,
    output logic [31:0]                  o_span_color,
    output logic                         o_last
);

    import tssg_pkg::*;

    localparam int C = COORD_BITS;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic                r_state;
    logic                r_active;
    logic signed [C-1:0] r_x0, r_y0, r_x1, r_y1, r_x2, r_y2;
    logic [31:0]         r_color;
    logic signed [C-1:0] r_row;

    logic                r_strobe;
    logic                r_span_valid;
    logic signed [C-1:0] r_orow;
    logic signed [C-1:0] r_lx;
    logic signed [C-1:0] r_sx;
    logic [31:0]         r_ocolor;
    logic                r_last;

    logic                accept;
    logic                unit_start;

    // Sort network temporaries
    logic signed [C-1:0] s1_px, s1_py, s1_qx, s1_qy;
    logic signed [C-1:0] s2_qx, s2_qy, s2_rx, s2_ry;
    logic signed [C-1:0] s3_px, s3_py, s3_qx, s3_qy;

    // Short edge selection
    logic                upper;
    logic signed [C-1:0] sh_xt, sh_yt, sh_xb, sh_yb;

    logic signed [C:0]   row_next;
    logic                fin;

    logic                long_done;
    logic                short_done;
    logic signed [C-1:0] long_x;
    logic signed [C-1:0] short_x;

    assign busy   = (r_state == ST_DIV);
    assign accept = start && !busy;

    // Stable three-element bubble sort on y: swap only on strictly greater
    always_comb begin
        if (i_ay > i_by) begin
            s1_px = i_bx; s1_py = i_by; s1_qx = i_ax; s1_qy = i_ay;
        end else begin
            s1_px = i_ax; s1_py = i_ay; s1_qx = i_bx; s1_qy = i_by;
        end
        if (s1_qy > i_cy) begin
            s2_qx = i_cx; s2_qy = i_cy; s2_rx = s1_qx; s2_ry = s1_qy;
        end else begin
            s2_qx = s1_qx; s2_qy = s1_qy; s2_rx = i_cx; s2_ry = i_cy;
        end
        if (s1_py > s2_qy) begin
            s3_px = s2_qx; s3_py = s2_qy; s3_qx = s1_px; s3_qy = s1_py;
        end else begin
            s3_px = s1_px; s3_py = s1_py; s3_qx = s2_qx; s3_qy = s2_qy;
        end
    end

    // Pick the upper short edge above the middle vertex, the lower one from there on
    always_comb begin
        upper = (r_row < r_y1);
        if (upper) begin
            sh_xt = r_x0; sh_yt = r_y0; sh_xb = r_x1; sh_yb = r_y1;
        end else begin
            sh_xt = r_x1; sh_yt = r_y1; sh_xb = r_x2; sh_yb = r_y2;
        end
    end

    // Final row check in one extra bit so the increment cannot wrap; compare signed
    always_comb begin
        row_next = $signed({r_row[C-1], r_row}) + $signed((C+1)'(1));
        fin      = (row_next >= $signed({r_y2[C-1], r_y2}));
    end

    assign unit_start = accept && (i_op == OP_STEP) && r_active;

    tssg_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_long (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (unit_start),
        .i_xt    (r_x0),
        .i_yt    (r_y0),
        .i_xb    (r_x2),
        .i_yb    (r_y2),
        .i_y     (r_row),
        .o_done  (long_done),
        .o_x     (long_x)
    );

    tssg_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_short (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (unit_start),
        .i_xt    (sh_xt),
        .i_yt    (sh_yt),
        .i_xb    (sh_xb),
        .i_yb    (sh_yb),
        .i_y     (r_row),
        .o_done  (short_done),
        .o_x     (short_x)
    );

    // Control, triangle state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_active <= 1'b0;
            r_strobe <= 1'b0;
            r_x0     <= '0;
            r_y0     <= '0;
            r_x1     <= '0;
            r_y1     <= '0;
            r_x2     <= '0;
            r_y2     <= '0;
            r_color  <= '0;
            r_row    <= '0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (i_op)
                            OP_LOAD: begin
                                r_x0     <= s3_px;
                                r_y0     <= s3_py;
                                r_x1     <= s3_qx;
                                r_y1     <= s3_qy;
                                r_x2     <= s2_rx;
                                r_y2     <= s2_ry;
                                r_color  <= i_fill_color;
                                r_row    <= s3_py;
                                r_active <= (s3_py < s2_ry);
                            end
                            OP_STEP: begin
                                if (r_active) begin
                                    r_state <= ST_DIV;
                                end else begin
                                    // Exhausted or never loaded: answer at once
                                    r_strobe     <= 1'b1;
                                    r_span_valid <= 1'b0;
                                    r_orow       <= '0;
                                    r_lx         <= '0;
                                    r_sx         <= '0;
                                    r_ocolor     <= '0;
                                    r_last       <= 1'b1;
                                end
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_DIV: begin
                    // Both units finish together; emit the span and advance the row
                    if (long_done && short_done) begin
                        r_strobe     <= 1'b1;
                        r_span_valid <= 1'b1;
                        r_orow       <= r_row;
                        r_lx         <= long_x;
                        r_sx         <= short_x;
                        r_ocolor     <= r_color;
                        r_last       <= fin;
                        r_row        <= row_next[C-1:0];
                        if (fin) begin
                            r_active <= 1'b0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_strobe       = r_strobe;
    assign o_span_valid   = r_span_valid;
    assign o_row          = r_orow;
    assign o_long_edge_x  = r_lx;
    assign o_short_edge_x = r_sx;
    assign o_span_color   = r_ocolor;
    assign o_last         = r_last;

endmodule : triangle_scanline_span_generator

>>> rtl/core/tssg_cross.sv
// Edge crossing unit: x = xt + (xb - xt) * (y - yt) / (yb - yt), truncated toward zero.
// Uses one magnitude multiply, then a restoring divider that yields one quotient bit per cycle.
// Depends on tssg_pkg for the default coordinate width.
`timescale 1ns / 1ps

module tssg_cross #(
    parameter int COORD_BITS = tssg_pkg::TSSG_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [COORD_BITS-1:0] i_xt,
    input  logic signed [COORD_BITS-1:0] i_yt,
    input  logic signed [COORD_BITS-1:0] i_xb,
    input  logic signed [COORD_BITS-1:0] i_yb,
    input  logic signed [COORD_BITS-1:0] i_y,
    output logic                         o_done,
    output logic signed [COORD_BITS-1:0] o_x
);

    import tssg_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int CNT_W = $clog2(C);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [C-1:0]         r_rem;
    logic [C-1:0]         r_num;
    logic [C-1:0]         r_quo;
    logic [C-1:0]         r_den;
    logic                 r_neg;
    logic signed [C-1:0]  r_xt;

    logic signed [C:0]    dx;
    logic signed [C:0]    dy_full;
    logic signed [C:0]    h_full;
    logic [C:0]           dx_abs;
    logic [2*C-1:0]       prod;
    logic [C:0]           rem_sh;
    logic [C:0]           rem_sub;
    logic                 ge;
    logic [C:0]           q_ext;
    logic [C:0]           q_signed;
    logic [C:0]           x_sum;

    // Form the edge deltas and the unsigned product of the numerator
    always_comb begin
        dx      = {i_xb[C-1], i_xb} - {i_xt[C-1], i_xt};
        dy_full = {i_y[C-1], i_y} - {i_yt[C-1], i_yt};
        h_full  = {i_yb[C-1], i_yb} - {i_yt[C-1], i_yt};
        dx_abs  = dx[C] ? ((C+1)'(0) - dx) : dx;
        prod    = {{C{1'b0}}, dx_abs[C-1:0]} * {{C{1'b0}}, dy_full[C-1:0]};
    end

    // One restoring step: shift in the next numerator bit, subtract if it fits
    always_comb begin
        rem_sh  = {r_rem, r_num[C-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        ge      = (rem_sh >= {1'b0, r_den});
    end

    // Apply the sign to the quotient and add the top x
    always_comb begin
        q_ext    = {1'b0, r_quo};
        q_signed = r_neg ? ((C+1)'(0) - q_ext) : q_ext;
        x_sum    = {r_xt[C-1], r_xt} + q_signed;
    end

    assign o_done = r_done;
    assign o_x    = x_sum[C-1:0];

    // Control: load on start, advance one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(C-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the high product half is already below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= prod[2*C-1:C];
            r_num <= prod[C-1:0];
            r_quo <= '0;
            r_den <= h_full[C-1:0];
            r_neg <= dx[C];
            r_xt  <= i_xt;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[C-1:0] : rem_sh[C-1:0];
            r_num <= {r_num[C-2:0], 1'b0};
            r_quo <= {r_quo[C-2:0], ge};
        end
    end

endmodule : tssg_cross

>>> verif/triangle_scanline_span_generator_checker.sv
// Span checker for the triangle scanline span generator: predicts each span and compares results.
// Depends on tssg_pkg for the operation codes and the coordinate width.
`timescale 1ns / 1ps

module triangle_scanline_span_generator_checker #(
    parameter int COORD_BITS = tssg_pkg::TSSG_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic                         i_op,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    input  logic [31:0]                  i_fill_color,
    input  logic                         o_strobe,
    input  logic                         o_span_valid,
    input  logic signed [COORD_BITS-1:0] o_row,
    input  logic signed [COORD_BITS-1:0] o_long_edge_x,
    input  logic signed [COORD_BITS-1:0] o_short_edge_x,
    input  logic [31:0]                  o_span_color,
    input  logic                         o_last,
    output int                           mismatches,
    output int                           spans_pending
);

    import tssg_pkg::*;

    typedef struct packed {
        logic                         span_valid;
        logic signed [COORD_BITS-1:0] row;
        logic signed [COORD_BITS-1:0] long_x;
        logic signed [COORD_BITS-1:0] short_x;
        logic [31:0]                  color;
        logic                         last;
    } t_span;

    // Predicted triangle state: vertices sorted by y, top first
    int          tri_x [3];
    int          tri_y [3];
    logic [31:0] tri_color;
    int          scan_row;
    logic        tri_active;

    t_span spans_due [$];

    initial begin
        mismatches    = 0;
        spans_pending = 0;
    end

    // Count a mismatch; print only the first ten
    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: mismatch on %s: expected 0x%08h, got 0x%08h", $realtime, what,
                     want, got);
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            flag_mismatch(what, want, got);
        end
    endtask

    // Crossing of an edge with a row, truncated toward zero
    function automatic int edge_cross(input int xt, input int yt, input int xb, input int yb,
                                      input int y);
        int h;
        h = yb - yt;
        if (h <= 0) begin
            return xt;
        end
        return xt + ((xb - xt) * (y - yt)) / h;
    endfunction

    // Sort the loaded vertices by y, keeping input order on ties
    task automatic load_triangle();
        int px [3];
        int py [3];
        int tx;
        int ty;
        px[0] = int'(i_ax);  py[0] = int'(i_ay);
        px[1] = int'(i_bx);  py[1] = int'(i_by);
        px[2] = int'(i_cx);  py[2] = int'(i_cy);
        for (int i = 1; i < 3; i++) begin
            for (int j = i; j > 0 && py[j-1] > py[j]; j--) begin
                tx = px[j];  ty = py[j];
                px[j] = px[j-1];  py[j] = py[j-1];
                px[j-1] = tx;  py[j-1] = ty;
            end
        end
        tri_x      = px;
        tri_y      = py;
        tri_color  = i_fill_color;
        scan_row   = py[0];
        tri_active = (py[0] < py[2]);
    endtask

    // Work out the span for one step item and advance the row
    task automatic predict_span(output t_span s);
        int lx;
        int sx;
        s = '0;
        if (!tri_active || scan_row < tri_y[0] || scan_row >= tri_y[2]) begin
            tri_active = 1'b0;
            s.last     = 1'b1;
            return;
        end
        lx = edge_cross(tri_x[0], tri_y[0], tri_x[2], tri_y[2], scan_row);
        if (scan_row < tri_y[1]) begin
            sx = edge_cross(tri_x[0], tri_y[0], tri_x[1], tri_y[1], scan_row);
        end else begin
            sx = edge_cross(tri_x[1], tri_y[1], tri_x[2], tri_y[2], scan_row);
        end
        s.span_valid = 1'b1;
        s.row        = COORD_BITS'(scan_row);
        s.long_x     = COORD_BITS'(lx);
        s.short_x    = COORD_BITS'(sx);
        s.color      = tri_color;
        s.last       = (scan_row + 1 >= tri_y[2]);
        scan_row     = scan_row + 1;
        if (s.last) begin
            tri_active = 1'b0;
        end
    endtask

    // Compare results first, then take in the item accepted at this edge
    always @(posedge i_clk) begin : watch
        t_span want;
        t_span next;
        if (!i_rst_n) begin
            tri_x      = '{0, 0, 0};
            tri_y      = '{0, 0, 0};
            tri_color  = '0;
            scan_row   = 0;
            tri_active = 1'b0;
            spans_due.delete();
        end else begin
            if (o_strobe === 1'b1) begin
                if (spans_due.size() == 0) begin
                    flag_mismatch("strobe with no span due", 32'h0, 32'h1);
                end else begin
                    want = spans_due.pop_front();
                    check_field("span_valid", 32'(want.span_valid), 32'(o_span_valid));
                    check_field("row", 32'(want.row), 32'(o_row));
                    check_field("long_edge_x", 32'(want.long_x), 32'(o_long_edge_x));
                    check_field("short_edge_x", 32'(want.short_x), 32'(o_short_edge_x));
                    check_field("span_color", want.color, o_span_color);
                    check_field("last", 32'(want.last), 32'(o_last));
                end
            end
            if (start && !busy) begin
                if (i_op == OP_LOAD) begin
                    load_triangle();
                end else begin
                    predict_span(next);
                    spans_due.push_back(next);
                end
            end
        end
        spans_pending = spans_due.size();
    end

endmodule : triangle_scanline_span_generator_checker

>>> verif/triangle_scanline_span_generator_tb.sv
// Testbench top for the triangle scanline span generator: clock, reset, stimulus and verdict.
// Depends on tssg_pkg and triangle_scanline_span_generator_checker; no files or arguments.
`timescale 1ns / 1ps

module triangle_scanline_span_generator_tb;
    import tssg_pkg::*;

    localparam int COORD_BITS      = TSSG_COORD_BITS;
    localparam int ITEM_TARGET     = 1400;
    localparam int QUIET_FROM      = 1200;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int SETTLE_CYCLES   = 40;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic                         i_op;
    logic signed [COORD_BITS-1:0] i_ax;
    logic signed [COORD_BITS-1:0] i_ay;
    logic signed [COORD_BITS-1:0] i_bx;
    logic signed [COORD_BITS-1:0] i_by;
    logic signed [COORD_BITS-1:0] i_cx;
    logic signed [COORD_BITS-1:0] i_cy;
    logic [31:0]                  i_fill_color;
    logic                         o_strobe;
    logic                         o_span_valid;
    logic signed [COORD_BITS-1:0] o_row;
    logic signed [COORD_BITS-1:0] o_long_edge_x;
    logic signed [COORD_BITS-1:0] o_short_edge_x;
    logic [31:0]                  o_span_color;
    logic                         o_last;

    int   mismatches;
    int   spans_pending;
    int   items_sent;
    int   idle_run;
    logic calm;

    triangle_scanline_span_generator #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_ax          (i_ax),
        .i_ay          (i_ay),
        .i_bx          (i_bx),
        .i_by          (i_by),
        .i_cx          (i_cx),
        .i_cy          (i_cy),
        .i_fill_color  (i_fill_color),
        .o_strobe      (o_strobe),
        .o_span_valid  (o_span_valid),
        .o_row         (o_row),
        .o_long_edge_x (o_long_edge_x),
        .o_short_edge_x(o_short_edge_x),
        .o_span_color  (o_span_color),
        .o_last        (o_last)
    );

    triangle_scanline_span_generator_checker #(
        .COORD_BITS(COORD_BITS)
    ) span_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_ax          (i_ax),
        .i_ay          (i_ay),
        .i_bx          (i_bx),
        .i_by          (i_by),
        .i_cx          (i_cx),
        .i_cy          (i_cy),
        .i_fill_color  (i_fill_color),
        .o_strobe      (o_strobe),
        .o_span_valid  (o_span_valid),
        .o_row         (o_row),
        .o_long_edge_x (o_long_edge_x),
        .o_short_edge_x(o_short_edge_x),
        .o_span_color  (o_span_color),
        .o_last        (o_last),
        .mismatches    (mismatches),
        .spans_pending (spans_pending)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog: end the run when nothing moves for too long
    initial idle_run = 0;
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe === 1'b1) begin
            idle_run <= 0;
        end else if (idle_run + 1 >= WATCHDOG_CYCLES) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    // Random coordinate over the full signed range
    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        return COORD_BITS'($urandom);
    endfunction

    // Drive one item at the falling edge and hold it until accepted
    task automatic send_item(input logic op,
                             input logic signed [COORD_BITS-1:0] ax,
                             input logic signed [COORD_BITS-1:0] ay,
                             input logic signed [COORD_BITS-1:0] bx,
                             input logic signed [COORD_BITS-1:0] by,
                             input logic signed [COORD_BITS-1:0] cx,
                             input logic signed [COORD_BITS-1:0] cy,
                             input logic [31:0] color);
        @(negedge i_clk);
        start        <= 1'b1;
        i_op         <= op;
        i_ax         <= ax;
        i_ay         <= ay;
        i_bx         <= bx;
        i_by         <= by;
        i_cx         <= cx;
        i_cy         <= cy;
        i_fill_color <= color;
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    // Drop start for a number of cycles
    task automatic pause_sender(input int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic maybe_idle();
        if (!calm && items_sent < QUIET_FROM && $urandom_range(0, 3) == 0) begin
            pause_sender($urandom_range(1, 8));
        end
    endtask

    // Step items carry random coordinates, which the block must ignore
    task automatic step_rows(input int count);
        repeat (count) begin
            send_item(OP_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), $urandom);
            maybe_idle();
        end
    endtask

    // Hold off the sender until every span due has come back
    task automatic drain_spans();
        @(negedge i_clk);
        start <= 1'b0;
        wait (spans_pending == 0);
    endtask

    // One random triangle and its steps, or a lone noise item
    task automatic run_triangle();
        int                           kind;
        int                           base;
        int                           lo;
        int                           hi;
        int                           steps;
        logic signed [COORD_BITS-1:0] ys [3];
        kind = $urandom_range(0, 15);
        calm = ($urandom_range(0, 3) == 0);
        if (kind == 0) begin
            send_item(1'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord(), $urandom);
            maybe_idle();
            return;
        end
        if (kind == 1) begin
            // full-range triangle: walk only a few rows of it
            for (int i = 0; i < 3; i++) ys[i] = rand_coord();
            steps = $urandom_range(1, 4);
        end else begin
            base = $urandom_range(0, 4095 - 16) - 2048;
            for (int i = 0; i < 3; i++) ys[i] = COORD_BITS'(base + $urandom_range(0, 16));
            if (kind == 2) begin
                ys[1] = ys[0];
                ys[2] = ys[0];
            end else if (kind == 3) begin
                ys[$urandom_range(1, 2)] = ys[0];
            end
            lo = int'(ys[0]);
            hi = int'(ys[0]);
            for (int i = 1; i < 3; i++) begin
                if (int'(ys[i]) < lo) lo = int'(ys[i]);
                if (int'(ys[i]) > hi) hi = int'(ys[i]);
            end
            steps = hi - lo + $urandom_range(0, 2);
            if ($urandom_range(0, 7) == 0) begin
                steps = $urandom_range(0, steps);
            end
        end
        send_item(OP_LOAD, rand_coord(), ys[0], rand_coord(), ys[1], rand_coord(), ys[2],
                  $urandom);
        maybe_idle();
        step_rows(steps);
    endtask

    initial begin
        logic drained;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_op         = OP_LOAD;
        i_ax         = '0;
        i_ay         = '0;
        i_bx         = '0;
        i_by         = '0;
        i_cx         = '0;
        i_cy         = '0;
        i_fill_color = '0;
        items_sent   = 0;
        calm         = 1'b1;
        drained      = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Step with no triangle ever loaded
        step_rows(1);
        // Tallest triangle, extreme corners and colour
        send_item(OP_LOAD, -2048, -2048, 2047, 0, 0, 2047, 32'hFFFF_FFFF);
        step_rows(2);
        // Bottom rows of the range, last span then exhausted
        send_item(OP_LOAD, 2047, 2047, -2048, 2045, 0, 2046, 32'h0000_0000);
        step_rows(3);
        // Flat top: upper half skipped
        send_item(OP_LOAD, 0, 5, 10, 5, 5, 8, 32'h1234_5678);
        step_rows(4);
        // Flat bottom: upper short edge only
        send_item(OP_LOAD, 3, 0, -4, 3, 9, 3, 32'hA5A5_5A5A);
        step_rows(3);
        // All three y equal: no rows at all
        send_item(OP_LOAD, -5, -7, 6, -7, 100, -7, 32'hDEAD_BEEF);
        step_rows(1);
        // Tied y below the top vertex keep their input order
        send_item(OP_LOAD, 100, -1, -100, -1, 0, -3, 32'h0F0F_F0F0);
        step_rows(3);
        drain_spans();

        // Random triangles, mostly well formed
        while (items_sent < ITEM_TARGET) begin
            if (!drained && items_sent >= ITEM_TARGET / 2) begin
                drain_spans();
                drained = 1'b1;
            end
            run_triangle();
        end

        @(negedge i_clk);
        start <= 1'b0;
        wait (spans_pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && spans_pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule : triangle_scanline_span_generator_tb
